[sv/pca_pkg.sv]
package pca_pkg;

   // payload widths
   localparam int SAMPLE_W   = 16;
   localparam int REQ_W      = 16;
   localparam int ERR_W      = 17;
   localparam int CHG_W      = 18;
   localparam int ACC_W      = 22;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int CLAMP_W    = 21;
   localparam int MUL_B_W    = 22;
   localparam int PROD_W     = GAIN_W + MUL_B_W;
   localparam int P_W        = 24;
   localparam int OUT_W      = 40;
   localparam int RSP_W      = 3 * OUT_W + P_W;

   // iterative divider: quotient bits retired per cycle
   localparam int DIV_W      = 40;
   localparam int DIV_BITS   = 8;
   localparam int DIV_CYCLES = DIV_W / DIV_BITS;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 21;
   localparam logic [CSR_ADDR_W-1:0] REG_TARGET     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_P     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_I     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_D     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_PROP_LIMIT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_ACCUM_MAX  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_ACCUM_MIN  = 3'd6;

   // microcode
   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] STEP_IDLE   = 3'd0;
   localparam logic [PC_W-1:0] STEP_UPDATE = 3'd1;
   localparam logic [PC_W-1:0] STEP_PCLAMP = 3'd2;
   localparam logic [PC_W-1:0] STEP_ITERM  = 3'd3;
   localparam logic [PC_W-1:0] STEP_DLOAD  = 3'd4;
   localparam logic [PC_W-1:0] STEP_DIV    = 3'd5;
   localparam logic [PC_W-1:0] STEP_DTERM  = 3'd6;
   localparam logic [PC_W-1:0] STEP_EMIT   = 3'd7;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_UPDATE,
      OP_PCLAMP,
      OP_ITERM,
      OP_DIVLOAD,
      OP_DIVSTEP,
      OP_DTERM,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_NO_REQ,
      COND_DIV_MORE,
      COND_RSP_BUSY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_W-1:0]     target;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_busy;
      logic div_last;
   } stat_type;

   typedef struct packed {
      logic busy;
      logic last;
   } div_stat_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] target;
      logic signed [GAIN_W-1:0]   gain_p;
      logic signed [GAIN_W-1:0]   gain_i;
      logic signed [GAIN_W-1:0]   gain_d;
      logic        [LIMIT_W-1:0]  prop_limit;
      logic signed [CLAMP_W-1:0]  accum_max;
      logic signed [CLAMP_W-1:0]  accum_min;
   } cfg_type;

   // control store: one word per step
   function automatic ctl_type ucode(input logic [PC_W-1:0] pc);
      ctl_type w;
      case (pc)
         STEP_IDLE:   w = '{op: OP_LOAD,    cond: COND_NO_REQ,   target: STEP_IDLE};
         STEP_UPDATE: w = '{op: OP_UPDATE,  cond: COND_NEXT,     target: STEP_IDLE};
         STEP_PCLAMP: w = '{op: OP_PCLAMP,  cond: COND_NEXT,     target: STEP_IDLE};
         STEP_ITERM:  w = '{op: OP_ITERM,   cond: COND_NEXT,     target: STEP_IDLE};
         STEP_DLOAD:  w = '{op: OP_DIVLOAD, cond: COND_NEXT,     target: STEP_IDLE};
         STEP_DIV:    w = '{op: OP_DIVSTEP, cond: COND_DIV_MORE, target: STEP_DIV};
         STEP_DTERM:  w = '{op: OP_DTERM,   cond: COND_NEXT,     target: STEP_IDLE};
         STEP_EMIT:   w = '{op: OP_EMIT,    cond: COND_RSP_BUSY, target: STEP_EMIT};
         default:     w = '{op: OP_LOAD,    cond: COND_NO_REQ,   target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

[sv/pca_seq.sv]
module pca_seq (
   input  logic               clock,
   input  logic               reset,
   input  pca_pkg::stat_type  stat,
   output pca_pkg::ctl_type   ctl
);

   logic [pca_pkg::PC_W-1:0] pc_ff;
   logic [pca_pkg::PC_W-1:0] pc_in;
   logic [pca_pkg::PC_W-1:0] pc_inc;

   assign ctl    = pca_pkg::ucode(pc_ff);
   assign pc_inc = pc_ff + pca_pkg::PC_W'(1);

   always_comb begin
      case (ctl.cond)
         pca_pkg::COND_NEXT:     pc_in = pc_inc;
         pca_pkg::COND_NO_REQ:   pc_in = stat.req_valid ? pc_inc : ctl.target;
         pca_pkg::COND_DIV_MORE: pc_in = stat.div_last ? pc_inc : ctl.target;
         pca_pkg::COND_RSP_BUSY: pc_in = stat.rsp_busy ? ctl.target : pc_inc;
         default:                pc_in = pc_inc;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= pca_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[sv/pca_div.sv]
module pca_div #(
   parameter int FILL_W = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pca_pkg::DIV_W-1:0]  dividend,
   input  logic [FILL_W-1:0]          divisor,
   output logic [pca_pkg::DIV_W-1:0]  quotient,
   output pca_pkg::div_stat_type      stat
);

   localparam int RW    = FILL_W + 1;
   localparam int CNT_W = $clog2(pca_pkg::DIV_CYCLES + 1);

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [pca_pkg::DIV_W-1:0] quo_ff, quo_in, quo_step;
   logic [FILL_W-1:0]         rem_ff, rem_in, rem_step;
   logic [FILL_W-1:0]         dvs_ff, dvs_in;

   // restoring division, several quotient bits per cycle; remainder stays below divisor
   always_comb begin
      logic [RW-1:0]             r;
      logic [pca_pkg::DIV_W-1:0] q;
      r = RW'(rem_ff);
      q = quo_ff;
      for (int k = 0; k < pca_pkg::DIV_BITS; k++) begin
         r = {r[FILL_W-1:0], q[pca_pkg::DIV_W-1]};
         q = {q[pca_pkg::DIV_W-2:0], 1'b0};
         if (r >= RW'(dvs_ff)) begin
            r    = r - RW'(dvs_ff);
            q[0] = 1'b1;
         end
      end
      rem_step = r[FILL_W-1:0];
      quo_step = q;
   end

   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = CNT_W'(pca_pkg::DIV_CYCLES);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         quo_in = quo_step;
         rem_in = rem_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.last = (cnt_ff == CNT_W'(1));

endmodule

[sv/pca_dp.sv]
module pca_dp #(
   parameter int WINDOW = 4,
   parameter int FILL_W = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pca_pkg::ctl_type           ctl,
   input  pca_pkg::cfg_type           cfg,
   input  logic                       clear,
   input  logic                       req_tvalid,
   input  logic [pca_pkg::REQ_W-1:0]  req_tdata,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [pca_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                       rsp_busy,
   output logic                       div_start,
   output logic [pca_pkg::DIV_W-1:0]  div_dividend,
   output logic [FILL_W-1:0]          div_divisor,
   input  logic [pca_pkg::DIV_W-1:0]  div_quotient
);

   localparam int SUM_W = pca_pkg::CHG_W + $clog2(WINDOW);

   logic signed [pca_pkg::ERR_W-1:0]   err_ff, err_in;
   logic signed [pca_pkg::ERR_W-1:0]   prev_ff, prev_in;
   logic signed [pca_pkg::ERR_W-1:0]   pprev_ff, pprev_in;
   logic signed [pca_pkg::CHG_W-1:0]   win_ff [WINDOW];
   logic signed [pca_pkg::CHG_W-1:0]   win_in [WINDOW];
   logic        [FILL_W-1:0]           fill_ff, fill_in;
   logic signed [SUM_W-1:0]            sum_ff, sum_in;
   logic signed [pca_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [pca_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [pca_pkg::P_W-1:0]     p_ff, p_in;
   logic signed [pca_pkg::PROD_W-1:0]  i_ff, i_in;
   logic signed [pca_pkg::OUT_W-1:0]   d_ff, d_in;
   logic                               neg_ff, neg_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic        [pca_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic signed [pca_pkg::SAMPLE_W-1:0] sample;
   logic signed [pca_pkg::CHG_W-1:0]    chg, last_chg, new_chg;
   logic                                full;
   logic signed [pca_pkg::ACC_W:0]      acc_sum;
   logic signed [pca_pkg::GAIN_W-1:0]   mul_a;
   logic signed [pca_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [pca_pkg::PROD_W-1:0]   lim;
   logic        [pca_pkg::PROD_W-1:0]   prod_mag;
   logic signed [pca_pkg::OUT_W-1:0]   drive;

   assign sample   = req_tdata[pca_pkg::SAMPLE_W-1:0];
   assign chg      = pca_pkg::CHG_W'(err_ff) - pca_pkg::CHG_W'(prev_ff);
   assign last_chg = pca_pkg::CHG_W'(prev_ff) - pca_pkg::CHG_W'(pprev_ff);
   // a flat error repeats the last change
   assign new_chg  = (chg != '0) ? chg : last_chg;
   assign full     = (fill_ff == FILL_W'(WINDOW));
   assign acc_sum  = (pca_pkg::ACC_W + 1)'(acc_ff) + (pca_pkg::ACC_W + 1)'(err_ff);
   assign lim      = $signed(pca_pkg::PROD_W'({cfg.prop_limit, 8'h00}));
   assign prod_mag = prod_ff[pca_pkg::PROD_W-1] ? (pca_pkg::PROD_W'(0) - prod_ff) : prod_ff;
   assign drive    = pca_pkg::OUT_W'(p_ff) + pca_pkg::OUT_W'(i_ff) + d_ff;

   // shared multiplier
   always_comb begin
      case (ctl.op)
         pca_pkg::OP_UPDATE: begin
            mul_a = cfg.gain_p;
            mul_b = pca_pkg::MUL_B_W'(err_ff);
         end
         pca_pkg::OP_PCLAMP: begin
            mul_a = cfg.gain_i;
            mul_b = pca_pkg::MUL_B_W'(acc_ff);
         end
         default: begin
            mul_a = cfg.gain_d;
            mul_b = pca_pkg::MUL_B_W'(sum_ff);
         end
      endcase
   end

   always_comb begin
      err_in       = err_ff;
      prev_in      = prev_ff;
      pprev_in     = pprev_ff;
      win_in       = win_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (ctl.op)
         pca_pkg::OP_LOAD: begin
            if (req_tvalid) begin
               err_in = pca_pkg::ERR_W'(cfg.target) - pca_pkg::ERR_W'(sample);
            end
         end
         pca_pkg::OP_UPDATE: begin
            // push the change; drop the oldest when the window is full
            for (int k = 0; k < WINDOW - 1; k++) begin
               if (full) begin
                  win_in[k] = win_ff[k+1];
               end else if (fill_ff == FILL_W'(k)) begin
                  win_in[k] = new_chg;
               end
            end
            if (full || fill_ff == FILL_W'(WINDOW - 1)) begin
               win_in[WINDOW-1] = new_chg;
            end
            if (full) begin
               sum_in = sum_ff + SUM_W'(new_chg) - SUM_W'(win_ff[0]);
            end else begin
               sum_in  = sum_ff + SUM_W'(new_chg);
               fill_in = fill_ff + FILL_W'(1);
            end
            // upper clamp wins when limits are inverted
            if (acc_sum > (pca_pkg::ACC_W + 1)'(cfg.accum_max)) begin
               acc_in = pca_pkg::ACC_W'(cfg.accum_max);
            end else if (acc_sum < (pca_pkg::ACC_W + 1)'(cfg.accum_min)) begin
               acc_in = pca_pkg::ACC_W'(cfg.accum_min);
            end else begin
               acc_in = pca_pkg::ACC_W'(acc_sum);
            end
            pprev_in = prev_ff;
            prev_in  = err_ff;
            prod_in  = mul_a * mul_b;
         end
         pca_pkg::OP_PCLAMP: begin
            if (prod_ff > lim) begin
               p_in = pca_pkg::P_W'(lim);
            end else if (prod_ff < -lim) begin
               p_in = pca_pkg::P_W'(-lim);
            end else begin
               p_in = pca_pkg::P_W'(prod_ff);
            end
            prod_in = mul_a * mul_b;
         end
         pca_pkg::OP_ITERM: begin
            i_in    = prod_ff;
            prod_in = mul_a * mul_b;
         end
         pca_pkg::OP_DIVLOAD: begin
            neg_in = prod_ff[pca_pkg::PROD_W-1];
         end
         pca_pkg::OP_DIVSTEP: begin
         end
         pca_pkg::OP_DTERM: begin
            d_in = neg_ff ? $signed(pca_pkg::OUT_W'(0) - div_quotient) : $signed(div_quotient);
         end
         pca_pkg::OP_EMIT: begin
            if (!rsp_busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {d_ff, pca_pkg::OUT_W'(i_ff), p_ff, drive};
            end
         end
         default: begin
         end
      endcase
      // new setpoint: drop all history
      if (clear) begin
         prev_in  = '0;
         pprev_in = '0;
         fill_in  = '0;
         sum_in   = '0;
         acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         pprev_ff     <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         pprev_ff     <= pprev_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      win_ff      <= win_in;
      prod_ff     <= prod_in;
      p_ff        <= p_in;
      i_ff        <= i_in;
      d_ff        <= d_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_busy     = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign div_start    = (ctl.op == pca_pkg::OP_DIVLOAD);
   assign div_dividend = pca_pkg::DIV_W'(prod_mag);
   assign div_divisor  = fill_ff;

`ifndef ASSERT_OFF
   a_fill_after_push: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == pca_pkg::OP_UPDATE && !clear) |=>
         (fill_ff != '0 && fill_ff <= FILL_W'(WINDOW)))
      else $error("window fill out of range after push");

   a_acc_clamped: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == pca_pkg::OP_UPDATE && !clear && cfg.accum_max >= cfg.accum_min) |=>
         (acc_ff <= pca_pkg::ACC_W'($past(cfg.accum_max)) &&
          acc_ff >= pca_pkg::ACC_W'($past(cfg.accum_min))))
      else $error("integrator escaped its clamps");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.op == pca_pkg::OP_EMIT))
      else $error("result beat raised outside the emit step");
`endif

endmodule

[sv/pid_clamped_avg_derivative.sv]
// A result beat follows the update, proportional clamp, integral, divider load, divide,
// derivative and emit steps; a new sample is taken only in the idle step, one at a time.
// The shared multiplier takes three steps and the divider by window fill retires 8
// quotient bits per cycle. A stalled result holds the sequencer in its last step.
// Reset (synchronous): the settings registers take their default values, all history
// is cleared, and the block is ready for a sample as soon as reset is released.
module pid_clamped_avg_derivative #(
   parameter int WINDOW = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pca_pkg::REQ_W-1:0]        req_tdata,   // [15:0] sample
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pca_pkg::RSP_W-1:0]        rsp_tdata,   // [39:0] drive, [63:40] p_term,
                                                         // [103:64] i_term, [143:104] d_term
   input  logic                             csr_we,
   input  logic [pca_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [pca_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int FILL_W = $clog2(WINDOW + 1);

   pca_pkg::cfg_type       cfg_ff, cfg_in;
   pca_pkg::ctl_type       ctl;
   pca_pkg::stat_type      stat;
   pca_pkg::div_stat_type  div_stat;
   logic                   clear;
   logic                   rsp_busy;
   logic                   div_start;
   logic [pca_pkg::DIV_W-1:0] div_dividend;
   logic [pca_pkg::DIV_W-1:0] div_quotient;
   logic [FILL_W-1:0]      div_divisor;

   assign clear = csr_we && (csr_addr == pca_pkg::REG_TARGET);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            pca_pkg::REG_TARGET:     cfg_in.target     = csr_wdata[15:0];
            pca_pkg::REG_GAIN_P:     cfg_in.gain_p     = csr_wdata[15:0];
            pca_pkg::REG_GAIN_I:     cfg_in.gain_i     = csr_wdata[15:0];
            pca_pkg::REG_GAIN_D:     cfg_in.gain_d     = csr_wdata[15:0];
            pca_pkg::REG_PROP_LIMIT: cfg_in.prop_limit = csr_wdata[14:0];
            pca_pkg::REG_ACCUM_MAX:  cfg_in.accum_max  = csr_wdata[20:0];
            pca_pkg::REG_ACCUM_MIN:  cfg_in.accum_min  = csr_wdata[20:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target     <= 16'sd0;
         cfg_ff.gain_p     <= 16'sd256;
         cfg_ff.gain_i     <= 16'sd0;
         cfg_ff.gain_d     <= 16'sd2560;
         cfg_ff.prop_limit <= 15'd12;
         cfg_ff.accum_max  <= 21'sd250;
         cfg_ff.accum_min  <= -21'sd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign stat.req_valid = req_tvalid;
   assign stat.rsp_busy  = rsp_busy;
   assign stat.div_last  = div_stat.last;

   assign req_tready = (ctl.op == pca_pkg::OP_LOAD);

   pca_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   pca_dp #(
      .WINDOW (WINDOW),
      .FILL_W (FILL_W)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .cfg          (cfg_ff),
      .clear        (clear),
      .req_tvalid   (req_tvalid),
      .req_tdata    (req_tdata),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata),
      .rsp_busy     (rsp_busy),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_quotient (div_quotient)
   );

   pca_div #(
      .FILL_W (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

`ifndef ASSERT_OFF
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_stat.busy)
      else $error("divider still running while a new sample is taken");
`endif

endmodule

[dv/pid_clamped_avg_derivative_check.sv]
`timescale 1ns / 1ps

module pid_clamped_avg_derivative_check #(
   parameter int WINDOW = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [pca_pkg::REQ_W-1:0]        req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [pca_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                             csr_we,
   input  logic [pca_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [pca_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               fail_count,
   output int                               outstanding
);

   // drive sits in the lowest bits of the result beat
   typedef struct packed {
      logic signed [pca_pkg::OUT_W-1:0] d_term;
      logic signed [pca_pkg::OUT_W-1:0] i_term;
      logic signed [pca_pkg::P_W-1:0]   p_term;
      logic signed [pca_pkg::OUT_W-1:0] drive;
   } pid_terms_type;

   // register copies
   logic signed [pca_pkg::SAMPLE_W-1:0] goal;
   logic signed [pca_pkg::GAIN_W-1:0]   kp;
   logic signed [pca_pkg::GAIN_W-1:0]   ki;
   logic signed [pca_pkg::GAIN_W-1:0]   kd;
   logic        [pca_pkg::LIMIT_W-1:0]  p_lim;
   logic signed [pca_pkg::CLAMP_W-1:0]  acc_hi;
   logic signed [pca_pkg::CLAMP_W-1:0]  acc_lo;

   // controller history
   longint last_err;
   longint older_err;
   longint integ;
   longint slope_hist [WINDOW];
   int     slope_cnt;

   pid_terms_type expected_terms [$];
   int            errors = 0;

   assign fail_count = errors;

   function automatic longint clip40(input longint v);
      longint hi_lim;
      longint lo_lim;
      hi_lim = (64'sd1 <<< (pca_pkg::OUT_W - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (v > hi_lim) return hi_lim;
      if (v < lo_lim) return lo_lim;
      return v;
   endfunction

   task clear_history();
      last_err  = 0;
      older_err = 0;
      integ     = 0;
      slope_cnt = 0;
      foreach (slope_hist[k]) slope_hist[k] = 0;
   endtask

   function pid_terms_type compute_terms(input logic signed [pca_pkg::SAMPLE_W-1:0] sample);
      longint        err;
      longint        chg;
      longint        last_chg;
      longint        lim;
      longint        p;
      longint        iv;
      longint        d;
      longint        tot;
      longint        hist_sum;
      pid_terms_type r;
      err      = longint'(goal) - longint'(sample);
      chg      = err - last_err;
      last_chg = last_err - older_err;
      lim      = longint'(p_lim) * 256;

      p = longint'(kp) * err;
      if (p > lim) p = lim;
      else if (p < -lim) p = -lim;

      // drop the oldest change once the window is full
      if (slope_cnt >= WINDOW) begin
         for (int k = 1; k < WINDOW; k++) slope_hist[k-1] = slope_hist[k];
         slope_cnt = WINDOW - 1;
      end
      slope_hist[slope_cnt] = (chg != 0) ? chg : last_chg;
      slope_cnt++;
      hist_sum = 0;
      for (int k = 0; k < slope_cnt; k++) hist_sum += slope_hist[k];
      d = clip40((longint'(kd) * hist_sum) / slope_cnt);

      // upper clamp wins when the limits are inverted
      integ = integ + err;
      if (integ > acc_hi) integ = acc_hi;
      else if (integ < acc_lo) integ = acc_lo;
      iv = clip40(integ * longint'(ki));

      older_err = last_err;
      last_err  = err;

      tot      = clip40(p + iv + d);
      r.drive  = tot[pca_pkg::OUT_W-1:0];
      r.p_term = p[pca_pkg::P_W-1:0];
      r.i_term = iv[pca_pkg::OUT_W-1:0];
      r.d_term = d[pca_pkg::OUT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      pid_terms_type want;
      pid_terms_type got;
      if (reset) begin
         goal      = '0;
         kp        = 16'sd256;
         ki        = '0;
         kd        = 16'sd2560;
         p_lim     = 15'd12;
         acc_hi    = 21'sd250;
         acc_lo    = -21'sd100;
         clear_history();
         expected_terms.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               pca_pkg::REG_TARGET: begin
                  goal = csr_wdata[pca_pkg::SAMPLE_W-1:0];
                  clear_history();
               end
               pca_pkg::REG_GAIN_P:     kp     = csr_wdata[pca_pkg::GAIN_W-1:0];
               pca_pkg::REG_GAIN_I:     ki     = csr_wdata[pca_pkg::GAIN_W-1:0];
               pca_pkg::REG_GAIN_D:     kd     = csr_wdata[pca_pkg::GAIN_W-1:0];
               pca_pkg::REG_PROP_LIMIT: p_lim  = csr_wdata[pca_pkg::LIMIT_W-1:0];
               pca_pkg::REG_ACCUM_MAX:  acc_hi = csr_wdata;
               pca_pkg::REG_ACCUM_MIN:  acc_lo = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_terms.insert(expected_terms.size(),
                                  compute_terms(req_tdata[pca_pkg::SAMPLE_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_terms.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result beat: drive %0d p %0d i %0d d %0d",
                           got.drive, got.p_term, got.i_term, got.d_term);
            end else begin
               want = expected_terms.pop_front();
               if (got.drive !== want.drive || got.p_term !== want.p_term ||
                   got.i_term !== want.i_term || got.d_term !== want.d_term) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("result beat wrong: expected drive %0d p %0d i %0d d %0d",
                              want.drive, want.p_term, want.i_term, want.d_term);
                     $display("                   actual   drive %0d p %0d i %0d d %0d",
                              got.drive, got.p_term, got.i_term, got.d_term);
                  end
               end
            end
         end
      end
      outstanding <= expected_terms.size();
   end

endmodule

[dv/pid_clamped_avg_derivative_test.sv]
`timescale 1ns / 1ps

module pid_clamped_avg_derivative_test;

   localparam int WINDOW         = 4;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 50;
   localparam logic [pca_pkg::CSR_ADDR_W-1:0] REG_SPARE = 3'd7;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [pca_pkg::REQ_W-1:0]          req_tdata  = '0;   // [15:0] sample
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [pca_pkg::RSP_W-1:0]          rsp_tdata;         // [39:0] drive, [63:40] p_term,
                                                          // [103:64] i_term, [143:104] d_term
   logic                               csr_we     = 1'b0;
   logic [pca_pkg::CSR_ADDR_W-1:0]     csr_addr   = '0;
   logic [pca_pkg::CSR_DATA_W-1:0]     csr_wdata  = '0;

   int fail_count;
   int outstanding;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet         = 0;

   logic [pca_pkg::CSR_ADDR_W-1:0] reg_list [8] = '{pca_pkg::REG_TARGET, pca_pkg::REG_GAIN_P,
                                                    pca_pkg::REG_GAIN_I, pca_pkg::REG_GAIN_D,
                                                    pca_pkg::REG_PROP_LIMIT,
                                                    pca_pkg::REG_ACCUM_MAX,
                                                    pca_pkg::REG_ACCUM_MIN, REG_SPARE};

   pid_clamped_avg_derivative #(.WINDOW(WINDOW)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   pid_clamped_avg_derivative_check #(.WINDOW(WINDOW)) i_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // restart the count on any beat or register write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_sample(input logic [pca_pkg::SAMPLE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off new samples until every result beat is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pca_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [pca_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   initial begin
      int level;
      int kind;
      logic [pca_pkg::CSR_DATA_W-1:0] value;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // default settings: extremes, repeated errors, window wrap, integrator clamps
      send_sample(16'sd0);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      send_sample(-16'sd32768);
      send_sample(-16'sd32768);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      send_sample(16'sd5);
      drain_results();

      // largest gains and limits, lowest setpoint
      write_reg(pca_pkg::REG_GAIN_P, 21'h007FFF);
      write_reg(pca_pkg::REG_GAIN_I, 21'h007FFF);
      write_reg(pca_pkg::REG_GAIN_D, 21'h007FFF);
      write_reg(pca_pkg::REG_PROP_LIMIT, 21'h007FFF);
      write_reg(pca_pkg::REG_ACCUM_MAX, 21'h0FFFFF);
      write_reg(pca_pkg::REG_ACCUM_MIN, 21'h100000);
      write_reg(pca_pkg::REG_TARGET, 21'h008000);
      csr_we <= 1'b0;
      send_sample(16'sd32767);
      send_sample(16'sd32767);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      send_sample(16'sd0);
      send_sample(16'sd100);
      send_sample(16'sd100);
      drain_results();

      // most negative gains, zero limit, inverted integrator limits, spare index
      write_reg(pca_pkg::REG_GAIN_P, 21'h008000);
      write_reg(pca_pkg::REG_GAIN_I, 21'h008000);
      write_reg(pca_pkg::REG_GAIN_D, 21'h008000);
      write_reg(pca_pkg::REG_PROP_LIMIT, 21'h000000);
      write_reg(pca_pkg::REG_ACCUM_MAX, 21'h100000);
      write_reg(pca_pkg::REG_ACCUM_MIN, 21'h0FFFFF);
      write_reg(pca_pkg::REG_TARGET, 21'h007FFF);
      write_reg(REG_SPARE, 21'h1FFFFF);
      csr_we <= 1'b0;
      send_sample(-16'sd32768);
      send_sample(16'sd32767);
      send_sample(16'sd0);
      send_sample(16'sd0);
      send_sample(16'sd12);
      send_sample(-16'sd5);
      drain_results();

      level = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 80; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 80; end
            default: begin send_idle_pct = 20; rsp_stall_pct = 20; end
         endcase

         foreach (reg_list[r]) begin
            if ($urandom_range(2) == 0) begin
               case ($urandom_range(3))
                  0: value = pca_pkg::CSR_DATA_W'($urandom_range(21'h1FFFFF));
                  1: value = pca_pkg::CSR_DATA_W'($urandom_range(600) - 300);
                  2: value = $urandom_range(1) ? 21'h0FFFFF : 21'h100000;
                  default: value = pca_pkg::CSR_DATA_W'($urandom_range(4095));
               endcase
               write_reg(reg_list[r], value);
            end
         end
         csr_we <= 1'b0;

         // mostly a slow walk with repeats so the window sees small and zero changes
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            kind = $urandom_range(9);
            if (kind <= 4) begin
               level = level + $urandom_range(8) - 4;
               if (level > 32767) level = 32767;
               if (level < -32768) level = -32768;
            end else if (kind == 7) begin
               level = $urandom_range(1) ? 32767 : -32768;
            end else if (kind >= 8) begin
               level = $urandom_range(65535) - 32768;
            end
            send_sample(level[pca_pkg::SAMPLE_W-1:0]);
         end
         drain_results();
      end

      repeat (20) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
